[rtl/core/cave_pkg.sv]
package cave_pkg;

   localparam int CFG_W = 7;
   localparam logic [CFG_W-1:0] MAP_SIZE_RESET = 7'd64;

   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_PASS  = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   localparam logic REG_MAP_WIDTH  = 1'b0;
   localparam logic REG_MAP_HEIGHT = 1'b1;

   localparam logic [3:0] WALL_KEEP_COUNT     = 4'd4;
   localparam logic [3:0] FLOOR_TO_WALL_COUNT = 4'd5;

   // 3x3 neighborhood, bit 0 = left column, bit 2 = right column
   typedef struct packed {
      logic [2:0] above;
      logic       left;
      logic       center;
      logic       right;
      logic [2:0] below;
   } window_type;

endpackage

[rtl/core/cave_cell_rule.sv]
module cave_cell_rule
   import cave_pkg::*;
(
   input  window_type win,
   output logic       wall
);

   logic [7:0] nbr;
   logic [3:0] count;

   always_comb begin
      nbr = {win.above, win.left, win.right, win.below};
      count = '0;
      for (int i = 0; i < 8; i++) begin
         count = count + 4'(nbr[i]);
      end
      wall = win.center ? (count >= WALL_KEEP_COUNT) : (count >= FLOOR_TO_WALL_COUNT);
   end

endmodule

[rtl/core/cave_automaton_smoothing_pass.sv]
// Cave smoothing block: a wall/floor grid held one row per memory word.
// Input channel req_*: one word per operation (write cell, smoothing pass,
// read cell). Result channel rsp_*: exactly one word per accepted item.
// CSR port csr_*: map_width at 0x0, map_height at 0x4; write only while idle.
// Items are handled one at a time. Steps from accept to result valid:
//   write in map: row read, then row write-back; read in map: row read;
//   out of map / unused op / empty map: none; pass: see below.
// A pass row costs a row fetch, a scan of each column and a row write-back
// through the row memory, which has a single read port.
// The next item can be taken in the cycle after the previous one leaves the engine,
// even while its result still waits in the output register.
// A stalled result holds; a finished item behind it waits in the engine.
// Reset: map size returns to 64 x 64, channels go empty. The grid is not
// cleared; cells hold unknown values until written.
module cave_automaton_smoothing_pass
   import cave_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
)
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [OP_W-1:0]   req_operation,
   input  logic [5:0]        req_column,
   input  logic [5:0]        req_row,
   input  logic              req_cell_value,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_read_value,
   output logic              rsp_out_of_range,

   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int UWW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
   localparam int UHW = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

   typedef enum logic [2:0] {
      S_IDLE, S_PRIME, S_LOAD, S_SCAN, S_STORE, S_WRITE, S_READ, S_RESULT
   } state_type;

   state_type            state_ff;
   logic [CFG_W-1:0]     map_width_ff;
   logic [CFG_W-1:0]     map_height_ff;

   logic [CW-1:0]        col_ff;
   logic [RW-1:0]        row_ff;
   logic                 val_ff;
   logic [CW-1:0]        c_ff;
   logic [RW-1:0]        r_ff;
   logic [MAX_WIDTH-1:0] prev_ff;
   logic [MAX_WIDTH-1:0] cur_ff;
   logic [MAX_WIDTH-1:0] next_ff;
   logic                 res_value_ff;
   logic                 res_oor_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_value_ff;
   logic                 rsp_oor_ff;

   logic [MAX_WIDTH-1:0] grid_mem [MAX_HEIGHT];
   logic [MAX_WIDTH-1:0] rdata_ff;

   logic                 rd_en;
   logic [RW-1:0]        raddr;
   logic                 wr_en;
   logic [RW-1:0]        waddr;
   logic [MAX_WIDTH-1:0] wdata;

   logic [UWW-1:0]       map_w_ext;
   logic [UHW-1:0]       map_h_ext;
   logic [UWW-1:0]       used_w;
   logic [UHW-1:0]       used_h;
   logic                 req_outside;
   logic                 map_empty;
   logic                 req_take;
   logic                 csr_wr;

   logic [CW-1:0]        c_left;
   logic [CW-1:0]        c_right;
   logic                 left_in;
   logic                 right_in;
   logic                 last_col;
   logic                 last_row;
   logic                 next_in;
   window_type           win;
   logic                 new_wall;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_MAP_HEIGHT) ? 32'(map_height_ff)
                                                        : 32'(map_width_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= MAP_SIZE_RESET;
         map_height_ff <= MAP_SIZE_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_MAP_WIDTH) begin
            map_width_ff <= csr_pwdata[CFG_W-1:0];
         end else begin
            map_height_ff <= csr_pwdata[CFG_W-1:0];
         end
      end
   end

   always_comb begin
      map_w_ext   = UWW'(map_width_ff);
      map_h_ext   = UHW'(map_height_ff);
      used_w      = (map_w_ext > UWW'(MAX_WIDTH))  ? UWW'(MAX_WIDTH)  : map_w_ext;
      used_h      = (map_h_ext > UHW'(MAX_HEIGHT)) ? UHW'(MAX_HEIGHT) : map_h_ext;
      req_outside = (UWW'(req_column) >= used_w) || (UHW'(req_row) >= used_h);
      map_empty   = (used_w == '0) || (used_h == '0);
   end

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid & ~req_stall;

   // scan window around (r_ff, c_ff); out-of-map neighbors are walls
   always_comb begin
      c_left   = c_ff - CW'(1);
      c_right  = c_ff + CW'(1);
      left_in  = (c_ff != '0);
      right_in = (UWW'(c_ff) + UWW'(1)) < used_w;
      last_col = (UWW'(c_ff) + UWW'(1)) == used_w;
      last_row = (UHW'(r_ff) + UHW'(1)) == used_h;
      next_in  = (UHW'(r_ff) + UHW'(1)) < used_h;

      win.above  = {right_in ? prev_ff[c_right] : 1'b1,
                    prev_ff[c_ff],
                    left_in  ? prev_ff[c_left]  : 1'b1};
      win.left   = left_in  ? cur_ff[c_left]  : 1'b1;
      win.center = cur_ff[c_ff];
      win.right  = right_in ? cur_ff[c_right] : 1'b1;
      win.below  = {right_in ? next_ff[c_right] : 1'b1,
                    next_ff[c_ff],
                    left_in  ? next_ff[c_left]  : 1'b1};
   end

   cave_cell_rule u_rule (
      .win  (win),
      .wall (new_wall)
   );

   // row memory port control
   always_comb begin
      rd_en = 1'b0;
      raddr = r_ff + RW'(1);
      wr_en = 1'b0;
      waddr = r_ff;
      wdata = cur_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_operation == OP_PASS) begin
               rd_en = req_take & ~map_empty;
               raddr = '0;
            end else begin
               rd_en = req_take & ~req_outside &
                       ((req_operation == OP_READ) || (req_operation == OP_WRITE));
               raddr = RW'(req_row);
            end
         end
         S_PRIME: begin
            rd_en = UHW'(1) < used_h;
            raddr = r_ff + RW'(1);
         end
         S_STORE: begin
            rd_en = (UHW'(r_ff) + UHW'(2)) < used_h;
            raddr = r_ff + RW'(2);
            wr_en = 1'b1;
            waddr = r_ff;
            wdata = cur_ff;
         end
         S_WRITE: begin
            wr_en = 1'b1;
            waddr = row_ff;
            wdata = rdata_ff;
            wdata[col_ff] = val_ff;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= grid_mem[raddr];
      end
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_RESULT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  col_ff <= CW'(req_column);
                  row_ff <= RW'(req_row);
                  val_ff <= req_cell_value;
                  r_ff   <= '0;
                  case (req_operation)
                     OP_WRITE: begin
                        res_value_ff <= 1'b0;
                        res_oor_ff   <= req_outside;
                        state_ff     <= req_outside ? S_RESULT : S_WRITE;
                     end
                     OP_READ: begin
                        res_value_ff <= req_outside;
                        res_oor_ff   <= req_outside;
                        state_ff     <= req_outside ? S_RESULT : S_READ;
                     end
                     OP_PASS: begin
                        res_value_ff <= 1'b0;
                        res_oor_ff   <= 1'b0;
                        state_ff     <= map_empty ? S_RESULT : S_PRIME;
                     end
                     default: begin
                        res_value_ff <= 1'b0;
                        res_oor_ff   <= 1'b0;
                        state_ff     <= S_RESULT;
                     end
                  endcase
               end
            end
            S_PRIME: begin
               cur_ff   <= rdata_ff;
               prev_ff  <= '1;
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               next_ff  <= next_in ? rdata_ff : '1;
               c_ff     <= '0;
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               cur_ff[c_ff] <= new_wall;
               if (last_col) begin
                  state_ff <= S_STORE;
               end else begin
                  c_ff <= c_ff + CW'(1);
               end
            end
            S_STORE: begin
               prev_ff <= cur_ff;
               cur_ff  <= next_ff;
               if (last_row) begin
                  state_ff <= S_RESULT;
               end else begin
                  r_ff     <= r_ff + RW'(1);
                  state_ff <= S_LOAD;
               end
            end
            S_WRITE: begin
               state_ff <= S_RESULT;
            end
            S_READ: begin
               res_value_ff <= rdata_ff[col_ff];
               state_ff     <= S_RESULT;
            end
            S_RESULT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= res_value_ff;
                  rsp_oor_ff   <= res_oor_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_value   = rsp_value_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESULT && rsp_valid_ff && rsp_stall) |=> (state_ff == S_RESULT))
      else $error("finished word overwrote a stalled result");

   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != S_IDLE))
      else $error("accepted word was dropped");

   a_no_row_collision: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en && (raddr == waddr)))
      else $error("row read and write hit the same row");

endmodule

[bench/cave_smoothing_checker.sv]
`timescale 1ns / 1ps

module cave_smoothing_checker
   import cave_pkg::*;
#(
   parameter int MAX_SIDE = 64
)
(
   input  logic            clock,
   input  logic            reset,

   input  logic            req_valid,
   input  logic            req_stall,
   input  logic [OP_W-1:0] req_operation,
   input  logic [5:0]      req_column,
   input  logic [5:0]      req_row,
   input  logic            req_cell_value,

   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  logic            rsp_read_value,
   input  logic            rsp_out_of_range,

   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [2:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   input  logic            csr_pready,

   output int              failures,
   output int              words_pending
);

   typedef struct packed {
      logic read_value;
      logic out_of_range;
   } cell_answer_type;

   cell_answer_type  cell_answers[$];
   logic             cave [MAX_SIDE][MAX_SIDE];   // [row][column]
   logic [CFG_W-1:0] map_width_q;
   logic [CFG_W-1:0] map_height_q;

   initial begin
      failures      = 0;
      words_pending = 0;
   end

   function automatic int used_span(logic [CFG_W-1:0] size);
      return (size > MAX_SIDE) ? MAX_SIDE : int'(size);
   endfunction

   // outside the map counts as wall
   function automatic int walls_around(int c, int r, int w, int h);
      int n;
      int nc;
      int nr;
      n = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) begin
               nc = c + dc;
               nr = r + dr;
               if (nc < 0 || nr < 0 || nc >= w || nr >= h) begin
                  n++;
               end else begin
                  n += int'(cave[nr][nc]);
               end
            end
         end
      end
      return n;
   endfunction

   // in place: later cells see updated cells above and to the left
   function automatic void smooth_map(int w, int h);
      int n;
      for (int r = 0; r < h; r++) begin
         for (int c = 0; c < w; c++) begin
            n = walls_around(c, r, w, h);
            if (cave[r][c]) begin
               cave[r][c] = (n >= WALL_KEEP_COUNT);
            end else begin
               cave[r][c] = (n >= FLOOR_TO_WALL_COUNT);
            end
         end
      end
   endfunction

   function automatic cell_answer_type cave_step(logic [OP_W-1:0] op, logic [5:0] col,
                                                 logic [5:0] row, logic val);
      cell_answer_type ans;
      int              w;
      int              h;
      logic            outside;
      w       = used_span(map_width_q);
      h       = used_span(map_height_q);
      outside = (int'(col) >= w) || (int'(row) >= h);
      ans     = '0;
      case (op)
         OP_WRITE: begin
            if (outside) begin
               ans.out_of_range = 1'b1;
            end else begin
               cave[row][col] = val;
            end
         end
         OP_PASS: begin
            smooth_map(w, h);
         end
         OP_READ: begin
            if (outside) begin
               ans.read_value   = 1'b1;
               ans.out_of_range = 1'b1;
            end else begin
               ans.read_value = cave[row][col];
            end
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      cell_answer_type want;
      if (reset) begin
         map_width_q  = MAP_SIZE_RESET;
         map_height_q = MAP_SIZE_RESET;
         cell_answers.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (cell_answers.size() == 0) begin
               failures++;
               $error("result word with nothing expected: read_value %0b out_of_range %0b",
                      rsp_read_value, rsp_out_of_range);
            end else begin
               want = cell_answers.pop_front();
               if (rsp_read_value !== want.read_value) begin
                  failures++;
                  $error("read_value: expected %0b, actual %0b",
                         want.read_value, rsp_read_value);
               end
               if (rsp_out_of_range !== want.out_of_range) begin
                  failures++;
                  $error("out_of_range: expected %0b, actual %0b",
                         want.out_of_range, rsp_out_of_range);
               end
            end
         end
         if (req_valid && !req_stall) begin
            cell_answers.push_back(cave_step(req_operation, req_column, req_row,
                                             req_cell_value));
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_MAP_WIDTH) begin
               map_width_q = csr_pwdata[CFG_W-1:0];
            end else begin
               map_height_q = csr_pwdata[CFG_W-1:0];
            end
         end
      end
      words_pending = cell_answers.size();
   end

endmodule

[bench/tb_cave_automaton_smoothing_pass.sv]
`timescale 1ns / 1ps

module tb_cave_automaton_smoothing_pass;
   import cave_pkg::*;

   localparam int MAX_SIDE      = 64;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int HOLD_OFF      = 300;
   localparam int DRAIN_CYCLES  = 20;
   localparam int PHASE_WORDS   = 10;
   localparam int NUM_PHASES    = 9;
   localparam int LOAD_W        = 6;
   localparam int LOAD_H        = 5;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   logic            clock            = 1'b0;
   logic            reset            = 1'b1;
   logic            req_valid        = 1'b0;
   logic            req_stall;
   logic [OP_W-1:0] req_operation    = OP_WRITE;
   logic [5:0]      req_column       = '0;
   logic [5:0]      req_row          = '0;
   logic            req_cell_value   = 1'b0;
   logic            rsp_valid;
   logic            rsp_stall        = 1'b0;
   logic            rsp_read_value;
   logic            rsp_out_of_range;
   logic            csr_psel         = 1'b0;
   logic            csr_penable      = 1'b0;
   logic            csr_pwrite       = 1'b0;
   logic [2:0]      csr_paddr        = '0;
   logic [31:0]     csr_pwdata       = '0;
   logic [31:0]     csr_prdata;
   logic            csr_pready;

   int fail_count;
   int words_pending;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_cycles        = 0;
   int cycle_count        = 0;
   int map_w              = MAX_SIDE;
   int map_h              = MAX_SIDE;
   int n_write            = 0;
   int n_read             = 0;
   int n_pass             = 0;
   int n_unused           = 0;
   int n_settings         = 0;

   bit cell_written [MAX_SIDE][MAX_SIDE];   // [row][column]

   int phase_w [NUM_PHASES] = '{5, 1, 6, 3, 127, 3, 0, 6, 2};
   int phase_h [NUM_PHASES] = '{4, 5, 2, 3, 100, 3, 5, 5, 1};

   cave_automaton_smoothing_pass dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_column       (req_column),
      .req_row          (req_row),
      .req_cell_value   (req_cell_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_value   (rsp_read_value),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   cave_smoothing_checker #(.MAX_SIDE(MAX_SIDE)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_column       (req_column),
      .req_row          (req_row),
      .req_cell_value   (req_cell_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_value   (rsp_read_value),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_pready       (csr_pready),
      .failures         (fail_count),
      .words_pending    (words_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: long hold-off when requested, else random stalls
   initial begin
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall = 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall = ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   function automatic bit map_written();
      for (int r = 0; r < map_h; r++) begin
         for (int c = 0; c < map_w; c++) begin
            if (!cell_written[r][c]) begin
               return 1'b0;
            end
         end
      end
      return 1'b1;
   endfunction

   task automatic send_word(logic [OP_W-1:0] op, int col, int row, logic val);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_operation  = op;
      req_column     = col[5:0];
      req_row        = row[5:0];
      req_cell_value = val;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (op == OP_WRITE && col < map_w && row < map_h) begin
         cell_written[row][col] = 1'b1;
      end
      case (op)
         OP_WRITE: n_write++;
         OP_READ:  n_read++;
         OP_PASS:  n_pass++;
         default:  n_unused++;
      endcase
   endtask

   task automatic csr_write(logic idx, int data);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic set_map(int w, int h);
      req_valid = 1'b0;
      while (words_pending != 0) @(negedge clock);
      csr_write(REG_MAP_WIDTH, w);
      csr_write(REG_MAP_HEIGHT, h);
      map_w = (w > MAX_SIDE) ? MAX_SIDE : w;
      map_h = (h > MAX_SIDE) ? MAX_SIDE : h;
      n_settings++;
   endtask

   task automatic send_random_word();
      int              pick;
      int              col;
      int              row;
      logic [OP_W-1:0] op;
      pick = $urandom_range(99);
      if (pick < 45) begin
         op = OP_WRITE;
      end else if (pick < 80) begin
         op = OP_READ;
      end else if (pick < 93) begin
         op = OP_PASS;
      end else begin
         op = OP_UNUSED;
      end
      // mostly inside the map, some anywhere
      if (map_w > 0 && $urandom_range(99) < 85) begin
         col = $urandom_range(map_w - 1);
      end else begin
         col = $urandom_range(MAX_SIDE - 1);
      end
      if (map_h > 0 && $urandom_range(99) < 85) begin
         row = $urandom_range(map_h - 1);
      end else begin
         row = $urandom_range(MAX_SIDE - 1);
      end
      // reads and passes only touch cells that hold a written value
      if (op == OP_READ && col < map_w && row < map_h && !cell_written[row][col]) begin
         op = OP_WRITE;
      end
      if (op == OP_PASS && !map_written()) begin
         op = OP_WRITE;
      end
      send_word(op, col, row, $urandom_range(1));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // load a small corner; reads and passes stay on written cells
      for (int r = 0; r < LOAD_H; r++) begin
         for (int c = 0; c < LOAD_W; c++) begin
            send_word(OP_WRITE, c, r, ($urandom_range(99) < 45));
         end
      end

      // full map at reset size
      send_word(OP_READ, 0, 0, 1'b0);
      send_word(OP_WRITE, 63, 63, 1'b1);
      send_word(OP_READ, 63, 63, 1'b0);
      send_word(OP_READ, LOAD_W - 1, LOAD_H - 1, 1'b0);

      // single cell: all neighbors are walls
      set_map(1, 1);
      send_word(OP_WRITE, 0, 0, 1'b1);
      send_word(OP_PASS, 0, 0, 1'b0);
      send_word(OP_READ, 0, 0, 1'b0);
      send_word(OP_WRITE, 0, 0, 1'b0);
      send_word(OP_PASS, 0, 0, 1'b0);
      send_word(OP_READ, 0, 0, 1'b0);
      send_word(OP_READ, 1, 0, 1'b0);
      send_word(OP_WRITE, 0, 1, 1'b1);
      send_word(OP_UNUSED, 63, 63, 1'b1);

      // empty map
      set_map(0, 64);
      send_word(OP_READ, 0, 0, 1'b0);
      send_word(OP_WRITE, 0, 0, 1'b1);
      send_word(OP_PASS, 0, 0, 1'b0);

      // oversized registers clamp to the full grid
      set_map(127, 127);
      send_word(OP_READ, 63, 63, 1'b0);
      send_word(OP_WRITE, 63, 63, 1'b0);
      send_word(OP_READ, 63, 63, 1'b0);
      send_word(OP_READ, LOAD_W - 1, 0, 1'b0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         set_map(phase_w[p], phase_h[p]);
         case (p % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 45;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 45;
            end
            default: begin
               sender_idle_pct    = 9;
               receiver_stall_pct = 9;
            end
         endcase
         if (p == 0) begin
            @(posedge clock);
            hold_cycles = HOLD_OFF;
            @(negedge clock);
         end
         repeat (PHASE_WORDS) send_random_word();
      end

      req_valid = 1'b0;
      while (words_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d words: %0d writes, %0d reads, %0d passes, %0d unused ops",
               n_write + n_read + n_pass + n_unused, n_write, n_read, n_pass, n_unused);
      $display("Map settings: %0d, incl. single cell, empty, oversized and full maps",
               n_settings + 1);
      if (fail_count == 0 && words_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
